// ----- src/udfb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// udfb_pkg
// shared constants for the dual serial-link byte buffer: opcodes, widths and
// default queue depth
// ----------------------------------------------------------------------------
package udfb_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int BYTE_W          = 8;
   localparam int OPCODE_W        = 2;
   localparam int LEVEL_W         = 5;

   localparam logic [OPCODE_W-1:0] OP_HOST_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_HOST_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LINE_RECV  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_TX_DONE    = 2'd3;

endpackage : udfb_pkg
`default_nettype wire

// ----- src/udfb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// udfb_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module udfb_ram #(
   parameter int WIDTH = udfb_pkg::BYTE_W,
   parameter int DEPTH = udfb_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : udfb_ram
`default_nettype wire

// ----- src/uart_dual_fifo_buffer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_dual_fifo_buffer_top
// send and receive byte queues between a host and a serial transmitter and
// receiver
// ----------------------------------------------------------------------------
// One event is taken every clock cycle; busy is always low. The result of an
// event appears on the rsp_ ports in the cycle after it is taken, for one
// cycle, marked by rsp_strobe, and cannot be held off by the receiver. The
// queue bytes in a result come from the registered read port of the two queue
// memories, which is read at the head pointer when the event is taken. Queue
// levels are reported modulo 32.
module uart_dual_fifo_buffer_top #(
   parameter int QUEUE_DEPTH = udfb_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [udfb_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [udfb_pkg::BYTE_W-1:0]       req_data_byte,
   output logic                                   rsp_strobe,
   output logic                                   rsp_line_send,
   output logic      [udfb_pkg::BYTE_W-1:0]       rsp_line_byte,
   output logic                                   rsp_read_valid,
   output logic      [udfb_pkg::BYTE_W-1:0]       rsp_read_byte,
   output logic                                   rsp_send_refused,
   output logic                                   rsp_recv_dropped,
   output logic      [udfb_pkg::LEVEL_W-1:0]      rsp_send_level,
   output logic      [udfb_pkg::LEVEL_W-1:0]      rsp_recv_level
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = udfb_pkg::LEVEL_W;
   localparam int BW = udfb_pkg::BYTE_W;

   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   logic          accept;

   logic [AW-1:0] send_head_ff, send_head_in;
   logic [AW-1:0] send_tail_ff, send_tail_in;
   logic [CW-1:0] send_count_ff, send_count_in;
   logic          tx_busy_ff, tx_busy_in;
   logic [AW-1:0] recv_head_ff, recv_head_in;
   logic [AW-1:0] recv_tail_ff, recv_tail_in;
   logic [CW-1:0] recv_count_ff, recv_count_in;

   logic          send_wr, send_rd, recv_wr, recv_rd;
   logic [BW-1:0] send_rdata, recv_rdata;

   logic          vld_ff;
   logic          line_send_ff, line_send_in;
   logic          from_queue_ff, from_queue_in;
   logic [BW-1:0] byte_ff;
   logic          read_valid_ff, read_valid_in;
   logic          refused_ff, refused_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] send_lev_ff, recv_lev_ff;

   logic [CW+LW-1:0] send_lev_ext, recv_lev_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
      wrap_next = (idx == LAST_IDX) ? '0 : idx + AW'(1);
   endfunction

   always_comb begin
      send_head_in  = send_head_ff;
      send_tail_in  = send_tail_ff;
      send_count_in = send_count_ff;
      tx_busy_in    = tx_busy_ff;
      recv_head_in  = recv_head_ff;
      recv_tail_in  = recv_tail_ff;
      recv_count_in = recv_count_ff;
      send_wr       = 1'b0;
      send_rd       = 1'b0;
      recv_wr       = 1'b0;
      recv_rd       = 1'b0;
      line_send_in  = 1'b0;
      from_queue_in = 1'b0;
      read_valid_in = 1'b0;
      refused_in    = 1'b0;
      dropped_in    = 1'b0;
      case (req_opcode)
         udfb_pkg::OP_HOST_WRITE: begin
            if (!tx_busy_ff) begin
               line_send_in = 1'b1;
               tx_busy_in   = 1'b1;
            end else if (send_count_ff == FULL_CNT) begin
               refused_in = 1'b1;
            end else begin
               send_wr       = 1'b1;
               send_tail_in  = wrap_next(send_tail_ff);
               send_count_in = send_count_ff + CW'(1);
            end
         end
         udfb_pkg::OP_HOST_READ: begin
            if (recv_count_ff != '0) begin
               read_valid_in = 1'b1;
               recv_rd       = 1'b1;
               recv_head_in  = wrap_next(recv_head_ff);
               recv_count_in = recv_count_ff - CW'(1);
            end
         end
         udfb_pkg::OP_LINE_RECV: begin
            if (recv_count_ff == FULL_CNT) begin
               dropped_in = 1'b1;
            end else begin
               recv_wr       = 1'b1;
               recv_tail_in  = wrap_next(recv_tail_ff);
               recv_count_in = recv_count_ff + CW'(1);
            end
         end
         udfb_pkg::OP_TX_DONE: begin
            if (send_count_ff == '0) begin
               tx_busy_in = 1'b0;
            end else begin
               line_send_in  = 1'b1;
               from_queue_in = 1'b1;
               send_rd       = 1'b1;
               send_head_in  = wrap_next(send_head_ff);
               send_count_in = send_count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_head_ff  <= '0;
         send_tail_ff  <= '0;
         send_count_ff <= '0;
         tx_busy_ff    <= 1'b0;
         recv_head_ff  <= '0;
         recv_tail_ff  <= '0;
         recv_count_ff <= '0;
         vld_ff        <= 1'b0;
      end else begin
         vld_ff <= accept;
         if (accept) begin
            send_head_ff  <= send_head_in;
            send_tail_ff  <= send_tail_in;
            send_count_ff <= send_count_in;
            tx_busy_ff    <= tx_busy_in;
            recv_head_ff  <= recv_head_in;
            recv_tail_ff  <= recv_tail_in;
            recv_count_ff <= recv_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_send_ff  <= line_send_in;
         from_queue_ff <= from_queue_in;
         byte_ff       <= req_data_byte;
         read_valid_ff <= read_valid_in;
         refused_ff    <= refused_in;
         dropped_ff    <= dropped_in;
         send_lev_ff   <= send_count_in;
         recv_lev_ff   <= recv_count_in;
      end
   end

   udfb_ram #(
      .WIDTH (BW),
      .DEPTH (QUEUE_DEPTH)
   ) u_send_ram (
      .clock   (clock),
      .wr_en   (accept && send_wr),
      .wr_addr (send_tail_ff),
      .wr_data (req_data_byte),
      .rd_en   (accept && send_rd),
      .rd_addr (send_head_ff),
      .rd_data (send_rdata)
   );

   udfb_ram #(
      .WIDTH (BW),
      .DEPTH (QUEUE_DEPTH)
   ) u_recv_ram (
      .clock   (clock),
      .wr_en   (accept && recv_wr),
      .wr_addr (recv_tail_ff),
      .wr_data (req_data_byte),
      .rd_en   (accept && recv_rd),
      .rd_addr (recv_head_ff),
      .rd_data (recv_rdata)
   );

   assign send_lev_ext = {{LW{1'b0}}, send_lev_ff};
   assign recv_lev_ext = {{LW{1'b0}}, recv_lev_ff};

   assign rsp_strobe       = vld_ff;
   assign rsp_line_send    = line_send_ff;
   assign rsp_line_byte    = !line_send_ff ? '0 : (from_queue_ff ? send_rdata : byte_ff);
   assign rsp_read_valid   = read_valid_ff;
   assign rsp_read_byte    = read_valid_ff ? recv_rdata : '0;
   assign rsp_send_refused = refused_ff;
   assign rsp_recv_dropped = dropped_ff;
   assign rsp_send_level   = send_lev_ext[LW-1:0];
   assign rsp_recv_level   = recv_lev_ext[LW-1:0];

   // idle transmitter means nothing is queued behind it
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !tx_busy_ff |-> send_count_ff == '0)
      else $error("send queue holds bytes while transmitter idle");

   a_send_bound: assert property (@(posedge clock) disable iff (reset)
      send_count_ff <= FULL_CNT && recv_count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      !reset && accept |=> rsp_strobe)
      else $error("accepted beat produced no result");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $countones({rsp_line_send, rsp_read_valid,
                                 rsp_send_refused, rsp_recv_dropped}) <= 1)
      else $error("result reports more than one action");

   a_refuse_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_send_refused |-> send_lev_ff == FULL_CNT && tx_busy_ff)
      else $error("write refused while send queue not full");

endmodule : uart_dual_fifo_buffer_top
`default_nettype wire

// ----- sim/uart_dual_fifo_buffer_top_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_dual_fifo_buffer_top_tb
// checks the send and receive byte queues of the serial-link buffer: a table
// of directed events, then random phases that fill and drain each queue; each
// result is compared field by field against its table row where the row is typed,
// else against a cycle-free model of both ring queues
module uart_dual_fifo_buffer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = udfb_pkg::QUEUE_DEPTH_DEF;
   localparam int BYTE_W     = udfb_pkg::BYTE_W;
   localparam int OPCODE_W   = udfb_pkg::OPCODE_W;
   localparam int LEVEL_W    = udfb_pkg::LEVEL_W;
   localparam int ITEM_GOAL  = 1950;
   localparam int STALL_MAX  = 500;

   typedef struct packed {
      logic                line_send;
      logic [BYTE_W-1:0]   line_byte;
      logic                read_valid;
      logic [BYTE_W-1:0]   read_byte;
      logic                send_refused;
      logic                recv_dropped;
      logic [LEVEL_W-1:0]  send_level;
      logic [LEVEL_W-1:0]  recv_level;
   } link_result_type;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [BYTE_W-1:0]   data;
      bit                  typed;
      link_result_type     res;
   } plan_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OPCODE_W-1:0]  req_opcode;
   logic [BYTE_W-1:0]    req_data_byte;
   logic                 rsp_strobe;
   logic                 rsp_line_send;
   logic [BYTE_W-1:0]    rsp_line_byte;
   logic                 rsp_read_valid;
   logic [BYTE_W-1:0]    rsp_read_byte;
   logic                 rsp_send_refused;
   logic                 rsp_recv_dropped;
   logic [LEVEL_W-1:0]   rsp_send_level;
   logic [LEVEL_W-1:0]   rsp_recv_level;

   uart_dual_fifo_buffer_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_line_send    (rsp_line_send),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_send_refused (rsp_send_refused),
      .rsp_recv_dropped (rsp_recv_dropped),
      .rsp_send_level   (rsp_send_level),
      .rsp_recv_level   (rsp_recv_level)
   );

   // model of both ring queues
   logic [BYTE_W-1:0] tx_mem [DEPTH];
   int                tx_rd;
   int                tx_wr;
   int                tx_cnt;
   bit                tx_active;
   logic [BYTE_W-1:0] rx_mem [DEPTH];
   int                rx_rd;
   int                rx_wr;
   int                rx_cnt;

   link_result_type   pending_results[$];
   plan_row_type      plan[$];
   bit                took;
   bit                row_typed;
   link_result_type   row_result;
   int                fail_count;
   int                stall_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic link_result_type advance_link(input logic [OPCODE_W-1:0] op,
                                                    input logic [BYTE_W-1:0] d);
      link_result_type r;
      r = '0;
      case (op)
         udfb_pkg::OP_HOST_WRITE: begin
            if (!tx_active) begin
               r.line_send = 1'b1;
               r.line_byte = d;
               tx_active = 1'b1;
            end else if (tx_cnt >= DEPTH) begin
               r.send_refused = 1'b1;
            end else begin
               tx_mem[tx_wr] = d;
               tx_wr = (tx_wr + 1) % DEPTH;
               tx_cnt++;
            end
         end
         udfb_pkg::OP_HOST_READ: begin
            if (rx_cnt != 0) begin
               r.read_valid = 1'b1;
               r.read_byte = rx_mem[rx_rd];
               rx_rd = (rx_rd + 1) % DEPTH;
               rx_cnt--;
            end
         end
         udfb_pkg::OP_LINE_RECV: begin
            if (rx_cnt >= DEPTH) begin
               r.recv_dropped = 1'b1;
            end else begin
               rx_mem[rx_wr] = d;
               rx_wr = (rx_wr + 1) % DEPTH;
               rx_cnt++;
            end
         end
         default: begin
            if (tx_cnt == 0) begin
               tx_active = 1'b0;
            end else begin
               r.line_send = 1'b1;
               r.line_byte = tx_mem[tx_rd];
               tx_rd = (tx_rd + 1) % DEPTH;
               tx_cnt--;
            end
         end
      endcase
      r.send_level = LEVEL_W'(tx_cnt);
      r.recv_level = LEVEL_W'(rx_cnt);
      return r;
   endfunction

   // result check and beat capture
   always @(posedge clock) begin
      link_result_type want;
      if (reset) begin
         took = 1'b0;
         stall_cycles = 0;
         tx_rd = 0; tx_wr = 0; tx_cnt = 0; tx_active = 1'b0;
         rx_rd = 0; rx_wr = 0; rx_cnt = 0;
      end else begin
         stall_cycles++;
         if (rsp_strobe) begin
            stall_cycles = 0;
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_line_send !== want.line_send) begin
                  $error("line_send exp %0d got %0d", want.line_send, rsp_line_send);
                  fail_count++;
               end
               if (rsp_line_byte !== want.line_byte) begin
                  $error("line_byte exp %0h got %0h", want.line_byte, rsp_line_byte);
                  fail_count++;
               end
               if (rsp_read_valid !== want.read_valid) begin
                  $error("read_valid exp %0d got %0d", want.read_valid, rsp_read_valid);
                  fail_count++;
               end
               if (rsp_read_byte !== want.read_byte) begin
                  $error("read_byte exp %0h got %0h", want.read_byte, rsp_read_byte);
                  fail_count++;
               end
               if (rsp_send_refused !== want.send_refused) begin
                  $error("send_refused exp %0d got %0d", want.send_refused,
                         rsp_send_refused);
                  fail_count++;
               end
               if (rsp_recv_dropped !== want.recv_dropped) begin
                  $error("recv_dropped exp %0d got %0d", want.recv_dropped,
                         rsp_recv_dropped);
                  fail_count++;
               end
               if (rsp_send_level !== want.send_level) begin
                  $error("send_level exp %0d got %0d", want.send_level, rsp_send_level);
                  fail_count++;
               end
               if (rsp_recv_level !== want.recv_level) begin
                  $error("recv_level exp %0d got %0d", want.recv_level, rsp_recv_level);
                  fail_count++;
               end
            end
         end
         took = start && !busy;
         if (took) begin
            stall_cycles = 0;
            want = advance_link(req_opcode, req_data_byte);
            if (row_typed) want = row_result;
            pending_results.push_back(want);
         end
         if (stall_cycles >= STALL_MAX) begin
            $display("FAIL uart_dual_fifo_buffer_top");
            $finish;
         end
      end
   end

   task automatic issue_beat(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] d,
                             input bit typed, input link_result_type res);
      req_opcode = op;
      req_data_byte = d;
      row_typed = typed;
      row_result = res;
      start = 1'b1;
      do @(negedge clock); while (!took);
   endtask

   task automatic pause_for(input int n);
      if (n > 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] d,
                          input int typed, input int ls, input logic [BYTE_W-1:0] lb,
                          input int rv, input logic [BYTE_W-1:0] rb,
                          input int sl, input int rl);
      plan_row_type row;
      row.op = op;
      row.data = d;
      row.typed = (typed != 0);
      row.res = '{1'(ls), lb, 1'(rv), rb, 1'b0, 1'b0, LEVEL_W'(sl), LEVEL_W'(rl)};
      plan.push_back(row);
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_op(input int w0, input int w1,
                                                   input int w2, input int w3);
      int r;
      r = $urandom_range(0, w0 + w1 + w2 + w3 - 1);
      if (r < w0) return udfb_pkg::OP_HOST_WRITE;
      if (r < w0 + w1) return udfb_pkg::OP_HOST_READ;
      if (r < w0 + w1 + w2) return udfb_pkg::OP_LINE_RECV;
      return udfb_pkg::OP_TX_DONE;
   endfunction

   initial begin
      int sent;
      int phase;
      int kind;
      int len;
      bit calm;
      int w [4];
      logic [OPCODE_W-1:0] op;

      fail_count = 0;
      sent = 0;
      start = 1'b0;
      req_opcode = udfb_pkg::OP_HOST_WRITE;
      req_data_byte = '0;
      row_typed = 1'b0;
      row_result = '0;
      reset = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // op, data, typed, line_send, line_byte, read_valid, read_byte, levels
      add_row(udfb_pkg::OP_HOST_READ,  8'h00, 1, 0, 8'h00, 0, 8'h00, 0, 0); // empty read
      add_row(udfb_pkg::OP_TX_DONE,    8'hFF, 1, 0, 8'h00, 0, 8'h00, 0, 0); // done idle
      add_row(udfb_pkg::OP_HOST_WRITE, 8'hFF, 1, 1, 8'hFF, 0, 8'h00, 0, 0); // idle write
      add_row(udfb_pkg::OP_HOST_WRITE, 8'h00, 1, 0, 8'h00, 0, 8'h00, 1, 0);
      add_row(udfb_pkg::OP_HOST_WRITE, 8'h80, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_TX_DONE,    8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_TX_DONE,    8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_TX_DONE,    8'h00, 1, 0, 8'h00, 0, 8'h00, 0, 0); // busy clears
      add_row(udfb_pkg::OP_TX_DONE,    8'h00, 1, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_LINE_RECV,  8'hFF, 1, 0, 8'h00, 0, 8'h00, 0, 1);
      add_row(udfb_pkg::OP_LINE_RECV,  8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_LINE_RECV,  8'h01, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_HOST_READ,  8'hFF, 1, 0, 8'h00, 1, 8'hFF, 0, 2);
      add_row(udfb_pkg::OP_HOST_READ,  8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_HOST_READ,  8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_HOST_READ,  8'h00, 1, 0, 8'h00, 0, 8'h00, 0, 0); // empty again
      add_row(udfb_pkg::OP_HOST_WRITE, 8'h7F, 1, 1, 8'h7F, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_HOST_WRITE, 8'h55, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_HOST_READ,  8'hAA, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_TX_DONE,    8'h00, 0, 0, 8'h00, 0, 8'h00, 0, 0);
      add_row(udfb_pkg::OP_TX_DONE,    8'h00, 1, 0, 8'h00, 0, 8'h00, 0, 0);

      foreach (plan[i]) begin
         issue_beat(plan[i].op, plan[i].data, plan[i].typed, plan[i].res);
         sent++;
         pause_for(gap_length());
      end
      drain_results();

      // fill/drain each queue first, then random phases
      phase = 0;
      while (sent < ITEM_GOAL) begin
         kind = (phase < 4) ? phase : $urandom_range(0, 5);
         len = (phase < 4) ? 32 : $urandom_range(20, 60);
         calm = ($urandom_range(0, 3) == 0);
         case (kind)
            0: w = '{12, 1, 1, 1};
            1: w = '{1, 1, 1, 12};
            2: w = '{1, 1, 12, 1};
            3: w = '{1, 12, 1, 1};
            4: w = '{1, 1, 1, 1};
            default: w = '{4, 1, 1, 4};
         endcase
         for (int k = 0; k < len; k++) begin
            op = pick_op(w[0], w[1], w[2], w[3]);
            issue_beat(op, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            sent++;
            if (!calm) pause_for(gap_length());
         end
         if (phase == 9) drain_results();
         phase++;
      end

      drain_results();
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS uart_dual_fifo_buffer_top");
      end else begin
         $display("FAIL uart_dual_fifo_buffer_top");
      end
      $finish;
   end

endmodule : uart_dual_fifo_buffer_top_tb
`default_nettype wire
